// File: rtl/svs_pkg.sv
// shared types and constants for the sample variance / standard deviation block
// no dependencies; imported by every module of the block except svs_queue
`timescale 1ns / 1ps

package svs_pkg;

    localparam int SMP_W           = 16;   // width of the sample field on the port
    localparam int RAW_W           = 24;   // widest supported sample width
    localparam int FRAC_W          = 8;    // fraction bits of the results
    localparam int VAR_W           = 39;
    localparam int SD_W            = 24;
    localparam int RAD_W           = 2 * SD_W;
    localparam int CNT_OUT_W       = 13;
    localparam int QUEUE_DEPTH     = 4;
    localparam int MAX_SAMPLES_DEF = 5000;
    localparam int SAMPLE_BITS_DEF = 16;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic                    last;
    } t_in;

    typedef struct packed {
        logic [VAR_W-1:0]     variance_q8;
        logic [SD_W-1:0]      stddev_q8;
        logic [CNT_OUT_W-1:0] sample_count;
        logic                 overflowed;
    } t_out;

endpackage

// File: rtl/svs_queue.sv
// small register queue carrying closed sets from the accumulator to the math engine
// generic width and depth; no package dependencies
`timescale 1ns / 1ps

module svs_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [W-1:0]  i_data,
    input  logic          i_pop,
    output logic [W-1:0]  o_data,
    output logic [CW-1:0] o_count
);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wr;
    logic [AW-1:0] n_rd;

    assign n_wr    = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
    assign n_rd    = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: rtl/svs_front.sv
// input side: takes samples, squares them and keeps the running count, sum and sum of squares
// depends on svs_pkg; hands each closed set to svs_queue
`timescale 1ns / 1ps

module svs_front #(
    parameter int MAX_SAMPLES  = svs_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS  = svs_pkg::SAMPLE_BITS_DEF,
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1),
    localparam int SUM_W       = SAMPLE_BITS + CNT_W,
    localparam int SQ_W        = 2 * SAMPLE_BITS - 1,
    localparam int S2_W        = SQ_W + CNT_W,
    localparam int SNAP_W      = SUM_W + S2_W + CNT_W + 1,
    localparam int QC_W        = $clog2(svs_pkg::QUEUE_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  svs_pkg::t_in      i_in,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [QC_W-1:0]   i_q_count,
    output logic              o_push,
    output logic [SNAP_W-1:0] o_snap
);

    import svs_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

    logic [RAW_W-1:0]                raw;
    logic signed [SAMPLE_BITS-1:0]   smp;
    logic                            accept;
    logic [QC_W:0]                   held;
    logic signed [2*SAMPLE_BITS-1:0] prod;

    logic                          r_s1_v;
    logic                          r_s1_last;
    logic signed [SAMPLE_BITS-1:0] r_s1_smp;
    logic                          r_s2_v;
    logic                          r_s2_last;
    logic signed [SAMPLE_BITS-1:0] r_s2_smp;
    logic [SQ_W-1:0]               r_s2_sq;

    logic signed [SUM_W-1:0] r_sum;
    logic [S2_W-1:0]         r_sq;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_drop;
    logic signed [SUM_W-1:0] n_sum;
    logic [S2_W-1:0]         n_sq;
    logic [CNT_W-1:0]        n_cnt;
    logic                    n_drop;
    logic                    take;

    // the sample is sign extended from its configured width, not from the port width
    assign raw = {{(RAW_W - SMP_W){1'b0}}, i_in.sample};
    assign smp = signed'(raw[SAMPLE_BITS-1:0]);

    // a closing word needs a queue slot; count those already in the pipe
    assign held = {1'b0, i_q_count} + (QC_W + 1)'(r_s1_v & r_s1_last)
                + (QC_W + 1)'(r_s2_v & r_s2_last);
    assign o_in_ready = (held < (QC_W + 1)'(QUEUE_DEPTH)) || !i_in.last;
    assign accept     = i_in_valid && o_in_ready;

    assign prod = r_s1_smp * r_s1_smp;

    always_comb begin
        take   = r_s2_v && (r_cnt < CNT_MAX);
        n_sum  = r_sum;
        n_sq   = r_sq;
        n_cnt  = r_cnt;
        n_drop = r_drop;
        if (take) begin
            n_sum = r_sum + SUM_W'(r_s2_smp);
            n_sq  = r_sq + S2_W'(r_s2_sq);
            n_cnt = r_cnt + CNT_W'(1);
        end else if (r_s2_v) begin
            n_drop = 1'b1;
        end
    end

    assign o_push = r_s2_v && r_s2_last;
    assign o_snap = {n_sum, n_sq, n_cnt, n_drop};

    always_ff @(posedge i_clk) begin
        r_s1_last <= i_in.last;
        r_s1_smp  <= smp;
        r_s2_last <= r_s1_last;
        r_s2_smp  <= r_s1_smp;
        r_s2_sq   <= prod[SQ_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_sum  <= '0;
            r_sq   <= '0;
            r_cnt  <= '0;
            r_drop <= 1'b0;
        end else begin
            r_s1_v <= accept;
            r_s2_v <= r_s1_v;
            if (o_push) begin
                r_sum  <= '0;
                r_sq   <= '0;
                r_cnt  <= '0;
                r_drop <= 1'b0;
            end else begin
                r_sum  <= n_sum;
                r_sq   <= n_sq;
                r_cnt  <= n_cnt;
                r_drop <= n_drop;
            end
        end
    end

endmodule

// File: rtl/svs_back.sv
// math engine: shift-add products, restoring divide and digit-by-digit square root
// depends on svs_pkg; reads closed sets from svs_queue and holds the result register
`timescale 1ns / 1ps

module svs_back #(
    parameter int MAX_SAMPLES  = svs_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS  = svs_pkg::SAMPLE_BITS_DEF,
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1),
    localparam int SUM_W       = SAMPLE_BITS + CNT_W,
    localparam int S2_W        = 2 * SAMPLE_BITS - 1 + CNT_W,
    localparam int SNAP_W      = SUM_W + S2_W + CNT_W + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SNAP_W-1:0] i_snap,
    input  logic              i_snap_valid,
    output logic              o_pop,
    output svs_pkg::t_out     o_out,
    output logic              o_out_valid,
    input  logic              i_out_ready
);

    import svs_pkg::*;

    localparam int MAG_W  = SUM_W - 1;
    localparam int D_W    = CNT_W + S2_W;
    localparam int NN_W   = 2 * CNT_W;
    localparam int DV_W   = D_W + FRAC_W;
    localparam int QX_W   = (DV_W > VAR_W) ? DV_W : VAR_W;
    localparam int STEP_W = $clog2(DV_W + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MULN = 3'd1;
    localparam logic [2:0] ST_MULM = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic signed [SUM_W-1:0] q_sum;
    logic signed [SUM_W-1:0] q_neg;
    logic [S2_W-1:0]         q_sq;
    logic [CNT_W-1:0]        q_cnt;
    logic                    q_drop;
    logic [MAG_W-1:0]        q_mag;
    logic [NN_W-1:0]         q_nn;

    logic [D_W-1:0]    acc_add;
    logic [D_W-1:0]    acc_sub;
    logic [NN_W:0]     rem_sh;
    logic              dge;
    logic [NN_W:0]     rem_diff;
    logic [DV_W-1:0]   quo;
    logic [QX_W-1:0]   qx;
    logic [SD_W+1:0]   srem_sh;
    logic [SD_W+1:0]   trial;
    logic              sge;
    logic              out_load;

    logic [2:0]        r_state,  n_state;
    logic [STEP_W-1:0] r_step,   n_step;
    logic [CNT_W-1:0]  r_n,      n_n;
    logic              r_drop,   n_drop;
    logic [MAG_W-1:0]  r_mag,    n_mag;
    logic [NN_W-1:0]   r_nn,     n_nn;
    logic [D_W-1:0]    r_mcand,  n_mcand;
    logic [MAG_W-1:0]  r_mplr,   n_mplr;
    logic [D_W-1:0]    r_acc,    n_acc;
    logic [DV_W-1:0]   r_dvd,    n_dvd;
    logic [NN_W-1:0]   r_rem,    n_rem;
    logic [VAR_W-1:0]  r_var,    n_var;
    logic [RAD_W-1:0]  r_rad,    n_rad;
    logic [SD_W-1:0]   r_root,   n_root;
    logic [SD_W+1:0]   r_srem,   n_srem;
    t_out              r_out,    n_out;
    logic              r_out_v,  n_out_v;

    assign q_sum  = signed'(i_snap[SNAP_W-1 -: SUM_W]);
    assign q_sq   = i_snap[CNT_W+1 +: S2_W];
    assign q_cnt  = i_snap[1 +: CNT_W];
    assign q_drop = i_snap[0];
    assign q_neg  = -q_sum;
    assign q_mag  = q_sum[SUM_W-1] ? q_neg[MAG_W-1:0] : q_sum[MAG_W-1:0];
    assign q_nn   = NN_W'(q_cnt) * NN_W'(q_cnt);

    assign o_pop   = (r_state == ST_IDLE) && i_snap_valid;
    assign acc_add = r_acc + r_mcand;
    assign acc_sub = r_acc - r_mcand;

    // restoring divide, one quotient bit per cycle
    assign rem_sh   = {r_rem, r_dvd[DV_W-1]};
    assign dge      = rem_sh >= {1'b0, r_nn};
    assign rem_diff = rem_sh - {1'b0, r_nn};
    assign quo      = {r_dvd[DV_W-2:0], dge};
    assign qx       = QX_W'(quo);

    // square root, two radicand bits per cycle
    assign srem_sh = {r_srem[SD_W-1:0], r_rad[RAD_W-1 -: 2]};
    assign trial   = {r_root, 2'b01};
    assign sge     = srem_sh >= trial;

    assign out_load = (r_state == ST_DONE) && (!r_out_v || i_out_ready);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_n     = r_n;
        n_drop  = r_drop;
        n_mag   = r_mag;
        n_nn    = r_nn;
        n_mcand = r_mcand;
        n_mplr  = r_mplr;
        n_acc   = r_acc;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        n_var   = r_var;
        n_rad   = r_rad;
        n_root  = r_root;
        n_srem  = r_srem;
        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    n_n     = q_cnt;
                    n_drop  = q_drop;
                    n_mag   = q_mag;
                    n_nn    = q_nn;
                    n_mcand = D_W'(q_sq);
                    n_mplr  = MAG_W'(q_cnt);
                    n_acc   = '0;
                    n_step  = '0;
                    n_state = ST_MULN;
                end
            end
            ST_MULN: begin
                // n * sum of squares
                n_acc   = r_mplr[0] ? acc_add : r_acc;
                n_mcand = r_mcand << 1;
                n_mplr  = r_mplr >> 1;
                n_step  = r_step + STEP_W'(1);
                if (r_step == STEP_W'(CNT_W - 1)) begin
                    n_mcand = D_W'(r_mag);
                    n_mplr  = r_mag;
                    n_step  = '0;
                    n_state = ST_MULM;
                end
            end
            ST_MULM: begin
                // minus sum squared, never goes below zero
                n_acc   = r_mplr[0] ? acc_sub : r_acc;
                n_mcand = r_mcand << 1;
                n_mplr  = r_mplr >> 1;
                n_step  = r_step + STEP_W'(1);
                if (r_step == STEP_W'(MAG_W - 1)) begin
                    n_dvd   = {n_acc, {FRAC_W{1'b0}}};
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_rem  = dge ? rem_diff[NN_W-1:0] : rem_sh[NN_W-1:0];
                n_dvd  = quo;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DV_W - 1)) begin
                    n_var   = (r_n == '0) ? '0 : qx[VAR_W-1:0];
                    n_rad   = RAD_W'({n_var, {FRAC_W{1'b0}}});
                    n_root  = '0;
                    n_srem  = '0;
                    n_step  = '0;
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                n_srem = sge ? srem_sh - trial : srem_sh;
                n_root = {r_root[SD_W-2:0], sge};
                n_rad  = r_rad << 2;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SD_W - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out   = r_out;
        n_out_v = r_out_v && !i_out_ready;
        if (out_load) begin
            n_out.variance_q8  = r_var;
            n_out.stddev_q8    = r_root;
            n_out.sample_count = CNT_OUT_W'(32'(r_n));
            n_out.overflowed   = r_drop;
            n_out_v            = 1'b1;
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_v;

    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_n     <= n_n;
        r_drop  <= n_drop;
        r_mag   <= n_mag;
        r_nn    <= n_nn;
        r_mcand <= n_mcand;
        r_mplr  <= n_mplr;
        r_acc   <= n_acc;
        r_dvd   <= n_dvd;
        r_rem   <= n_rem;
        r_var   <= n_var;
        r_rad   <= n_rad;
        r_root  <= n_root;
        r_srem  <= n_srem;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_v <= n_out_v;
        end
    end

endmodule

// File: rtl/sample_variance_stddev.sv
// Population variance and standard deviation over sets of signed samples.
// Input channel (i_in, i_in_valid / o_in_ready): one sample word per cycle; the word
// with last set closes the set. Output channel (o_out, o_out_valid / i_out_ready): one
// result word per set with variance and standard deviation in Q.8, the sample count
// and a flag that samples past MAX_SAMPLES were dropped.
// Throughput: one sample word per cycle while o_in_ready is high, set by the two-stage
// square and accumulate pipe. Each closed set then passes through the multiply,
// multiply-subtract, divide and square root states of the single shared math engine
// and waits in its done state until the result register takes it; the engine takes
// a new set from the queue only once it is back in its idle state.
// A four-entry queue holds closed sets; when it is full a closing word waits
// (o_in_ready low), while ordinary sample words keep flowing.
// A stalled receiver holds the result in the output register; the engine then waits
// in its done state and the queue absorbs further sets.
// Reset (i_rst_n low, synchronous) clears the running sums, queue and result valid.
// depends on svs_pkg, svs_front, svs_queue, svs_back
`timescale 1ns / 1ps

module sample_variance_stddev #(
    parameter int MAX_SAMPLES = svs_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = svs_pkg::SAMPLE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  svs_pkg::t_in  i_in,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output svs_pkg::t_out o_out,
    output logic          o_out_valid,
    input  logic          i_out_ready
);

    import svs_pkg::*;

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int S2_W   = 2 * SAMPLE_BITS - 1 + CNT_W;
    localparam int SNAP_W = SUM_W + S2_W + CNT_W + 1;
    localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);

    logic              push;
    logic              pop;
    logic [SNAP_W-1:0] snap_in;
    logic [SNAP_W-1:0] snap_out;
    logic [QC_W-1:0]   q_count;

    svs_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_q_count  (q_count),
        .o_push     (push),
        .o_snap     (snap_in)
    );

    svs_queue #(
        .W     (SNAP_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (snap_in),
        .i_pop   (pop),
        .o_data  (snap_out),
        .o_count (q_count)
    );

    svs_back #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap       (snap_out),
        .i_snap_valid (q_count != '0),
        .o_pop        (pop),
        .o_out        (o_out),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready)
    );

    // slot reservation in the front must keep the queue from overrunning
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (q_count < QC_W'(QUEUE_DEPTH)))
        else $error("closed set pushed into a full queue");

    a_root_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((RAD_W + 1)'(o_out.stddev_q8) * (RAD_W + 1)'(o_out.stddev_q8)
            <= (RAD_W + 1)'({o_out.variance_q8, {FRAC_W{1'b0}}})))
        else $error("standard deviation too large for variance");

    a_root_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (((RAD_W + 1)'(o_out.stddev_q8) + (RAD_W + 1)'(1))
            * ((RAD_W + 1)'(o_out.stddev_q8) + (RAD_W + 1)'(1))
            > (RAD_W + 1)'({o_out.variance_q8, {FRAC_W{1'b0}}})))
        else $error("standard deviation too small for variance");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid right after reset");

endmodule
